FILE: rtl/pls_pkg.sv
// Shared types and constants of the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

    // Field widths fixed by the transaction format.
    localparam int KW = 2;   // request kind
    localparam int PW = 8;   // position, found position and count
    localparam int VW = 32;  // element value

    // Request kinds.
    typedef enum logic [KW-1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_GET    = 2'd2,
        K_LOCATE = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // latch a new request and set up the walk
        logic rd;    // read one entry
        logic use_d; // act on the entry just read
        logic put;   // write the inserted value
        logic fin;   // load the result register
    } t_pls_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;     // another entry must be read
        logic put_req;  // a valid insert still needs its final write
    } t_pls_sts;

endpackage

FILE: rtl/pls_ctrl.sv
// Controller state machine of the positional list store.
`timescale 1ns / 1ps

module pls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    input  pls_pkg::t_pls_sts i_sts,
    output pls_pkg::t_pls_cmd o_cmd
);
    import pls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_RD,
        S_USE,
        S_PUT,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = o_s_tready && i_s_tvalid;
        o_cmd.rd    = (r_state == S_RD);
        o_cmd.use_d = (r_state == S_USE);
        o_cmd.put   = (r_state == S_PUT);
        o_cmd.fin   = (r_state == S_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A new result taking the register overrides the drain of the old one.
            if (r_out_valid && i_m_tready && !o_cmd.fin) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    priority if (i_sts.more) begin
                        r_state <= S_RD;
                    end else if (i_sts.put_req) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RD:  r_state <= S_USE;
                S_USE: r_state <= S_CHK;
                S_PUT: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/pls_dpath.sv
// Datapath of the positional list store: entry memory, length, walk index, result.
`timescale 1ns / 1ps

module pls_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pls_pkg::KW-1:0]    i_req_type,
    input  logic [pls_pkg::PW-1:0]    i_position,
    input  logic signed [pls_pkg::VW-1:0] i_value,
    input  pls_pkg::t_pls_cmd         i_cmd,
    output pls_pkg::t_pls_sts         o_sts,
    output logic                      o_ok,
    output logic signed [pls_pkg::VW-1:0] o_element,
    output logic [pls_pkg::PW-1:0]    o_found_position,
    output logic [pls_pkg::PW-1:0]    o_count
);
    import pls_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);  // length and walk index
    localparam int IW = $clog2(CAPACITY);      // memory address

    logic [VW-1:0] r_mem [CAPACITY];
    logic [VW-1:0] r_rdata;

    t_kind         r_kind;
    logic [PW-1:0] r_pos;
    logic [VW-1:0] r_val;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_idx;
    logic          r_ok;
    logic          r_done;
    logic [VW-1:0] r_elem;
    logic [PW-1:0] r_found;

    logic          r_o_ok;
    logic [VW-1:0] r_o_elem;
    logic [PW-1:0] r_o_found;
    logic [PW-1:0] r_o_count;

    logic          ins_ok;
    logic          rd_ok;
    logic [PW-1:0] pos_m1;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
    logic [LW-1:0] n_len;

    // Checks on the incoming request against the current length.
    assign ins_ok = (i_position != '0)
                 && ({1'b0, i_position} <= ((PW+1)'(r_len) + (PW+1)'(1)))
                 && (r_len < LW'(CAPACITY));
    assign rd_ok  = (i_position != '0) && (i_position <= PW'(r_len));
    assign pos_m1 = r_pos - PW'(1);

    always_comb begin
        o_sts = '0;
        unique case (r_kind)
            K_INSERT: o_sts.more = r_ok && (PW'(r_idx) >= r_pos);
            K_DELETE: o_sts.more = r_ok && (r_idx < r_len);
            K_GET:    o_sts.more = r_ok && !r_done;
            K_LOCATE: o_sts.more = (r_idx < r_len) && (r_found == '0);
            default:  o_sts.more = 1'b0;
        endcase
        o_sts.put_req = (r_kind == K_INSERT) && r_ok;
    end

    // Insert reads the entry below its destination; the others read at the index.
    assign rd_addr = (r_kind == K_INSERT) ? IW'(r_idx - LW'(1)) : IW'(r_idx);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = IW'(r_idx);
        wr_data = r_rdata;
        if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = IW'(pos_m1);
            wr_data = r_val;
        end else if (i_cmd.use_d) begin
            if (r_kind == K_INSERT) begin
                wr_en = 1'b1;
            end else if (r_kind == K_DELETE && PW'(r_idx) != pos_m1) begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_idx - LW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_len = r_len;
        if (r_ok && r_kind == K_INSERT) begin
            n_len = r_len + LW'(1);
        end else if (r_ok && r_kind == K_DELETE) begin
            n_len = r_len - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.fin) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_req_type);
            r_pos   <= i_position;
            r_val   <= i_value;
            r_done  <= 1'b0;
            r_elem  <= '0;
            r_found <= '0;
            unique case (t_kind'(i_req_type))
                K_INSERT: begin
                    r_ok  <= ins_ok;
                    r_idx <= r_len;
                end
                K_DELETE, K_GET: begin
                    r_ok  <= rd_ok;
                    r_idx <= LW'(i_position - PW'(1));
                end
                K_LOCATE: begin
                    r_ok  <= 1'b1;
                    r_idx <= '0;
                end
                default: begin
                    r_ok  <= 1'b0;
                    r_idx <= '0;
                end
            endcase
        end else if (i_cmd.use_d) begin
            unique case (r_kind)
                K_INSERT: r_idx <= r_idx - LW'(1);
                K_DELETE: begin
                    if (PW'(r_idx) == pos_m1) begin
                        r_elem <= r_rdata;
                    end
                    r_idx <= r_idx + LW'(1);
                end
                K_GET: begin
                    r_elem <= r_rdata;
                    r_done <= 1'b1;
                end
                K_LOCATE: begin
                    if (r_rdata == r_val) begin
                        r_found <= PW'(r_idx) + PW'(1);
                    end
                    r_idx <= r_idx + LW'(1);
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_ok    <= r_ok;
            r_o_elem  <= r_elem;
            r_o_found <= r_found;
            r_o_count <= PW'(n_len);
        end
    end

    assign o_ok             = r_o_ok;
    assign o_element        = r_o_elem;
    assign o_found_position = r_o_found;
    assign o_count          = r_o_count;

endmodule

FILE: rtl/positional_list_store.sv
// Top level of the positional list store: ordered list with insert, delete, get, locate.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s (req)   in         i_s_tvalid/o_s_tready tuser: req_type; tdata: position, value
// m (res)   out        o_m_tvalid/i_m_tready tdata: ok, element, found_position, count
//
// One request is worked on at a time. Its result is loaded after a walk over the
// k entries moved or scanned; each entry costs a read of the single memory port,
// its registered data, and a loop check. A valid insert adds its final write.
// The block passes through idle again before it accepts the next request.
// The synchronous reset empties the list at once; there is no clearing pass, and
// the request side is not ready while reset is held.
// A result waiting on a stalled master side does not block the next request,
// which is accepted and worked on until it needs the result register.
module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // position [7:0], value [39:8]
    input  logic [1:0]  i_s_tuser,  // req_type [1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata   // ok [0], element [32:1], found_position [40:33],
                                    // count [48:41], zero [55:49]
);
    import pls_pkg::*;

    t_pls_cmd             cmd;
    t_pls_sts             sts;
    logic                 res_ok;
    logic signed [VW-1:0] res_element;
    logic [PW-1:0]        res_found;
    logic [PW-1:0]        res_count;

    // The controller sequences each request; the datapath holds the list.
    pls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pls_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_type       (i_s_tuser),
        .i_position       (i_s_tdata[7:0]),
        .i_value          (i_s_tdata[39:8]),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_ok             (res_ok),
        .o_element        (res_element),
        .o_found_position (res_found),
        .o_count          (res_count)
    );

    // Pack the result fields from the lowest bit up and pad to whole bytes.
    assign o_m_tdata = {7'd0, res_count, res_found, res_element, res_ok};

endmodule

FILE: rtl/pls_checker.sv
// Port-level checks of the positional list store, bound to the top level.
`timescale 1ns / 1ps

module pls_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // One request at a time: after acceptance the request side closes.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request accepted during work");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A found position comes with success, no element, and lies within the list.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[40:33] != 8'd0 |->
            o_m_tdata[0] && o_m_tdata[32:1] == 32'd0 && o_m_tdata[40:33] <= o_m_tdata[48:41])
        else $error("inconsistent locate result");

endmodule

bind positional_list_store pls_port_checks u_pls_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/pls_checker.sv
// Checker for the positional list store: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module pls_checker
    import pls_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,  // position [7:0], value [39:8]
    input  logic [1:0]  i_s_tuser,  // req_type [1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,  // ok [0], element [32:1], found_position [40:33],
                                    // count [48:41], zero [55:49]
    output int          o_mismatches,
    output int          o_pending,
    output logic [7:0]  o_list_len
);

    typedef struct {
        logic          ok;
        logic [VW-1:0] element;
        logic [PW-1:0] found;
        logic [PW-1:0] count;
    } list_reply_t;

    // Shadow copy of the list and the replies still owed by the block.
    logic [VW-1:0] shadow_list [CAPACITY];
    int            shadow_len;
    list_reply_t   replies_due [$];
    int            reply_seq;
    int            mismatches;

    assign o_mismatches = mismatches;

    initial begin
        shadow_len  = 0;
        reply_seq   = 0;
        mismatches  = 0;
        o_pending   = 0;
        o_list_len  = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("pls_checker: transaction %0d: %s", reply_seq, msg);
        mismatches++;
    endtask

    // Applies one request to the shadow list and returns the reply it calls for.
    function automatic list_reply_t apply_request(t_kind kind, logic [PW-1:0] pos,
                                                  logic [VW-1:0] val);
        list_reply_t r;
        int          p;
        int          j;
        r.ok      = 1'b0;
        r.element = '0;
        r.found   = '0;
        p         = int'(pos);
        case (kind)
            K_INSERT: begin
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY) begin
                    for (j = shadow_len; j >= p; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[p-1] = val;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            end
            K_DELETE: begin
                if (p >= 1 && p <= shadow_len) begin
                    r.element = shadow_list[p-1];
                    for (j = p; j < shadow_len; j++)
                        shadow_list[j-1] = shadow_list[j];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            K_GET: begin
                if (p >= 1 && p <= shadow_len) begin
                    r.element = shadow_list[p-1];
                    r.ok      = 1'b1;
                end
            end
            default: begin
                // Locate always succeeds; the first matching entry wins.
                r.ok = 1'b1;
                for (j = 0; j < shadow_len; j++) begin
                    if (shadow_list[j] == val) begin
                        r.found = PW'(j + 1);
                        break;
                    end
                end
            end
        endcase
        r.count = PW'(shadow_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        list_reply_t want;
        if (!i_rst_n) begin
            shadow_len = 0;
            replies_due.delete();
        end else begin
            // A result can never belong to the request taken at the same edge,
            // so the result side is handled first.
            if (i_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("result 0x%h with none expected", i_m_tdata));
                end else begin
                    want = replies_due.pop_front();
                    if (i_m_tdata[0] !== want.ok)
                        report_mismatch($sformatf("ok got %b want %b",
                                                  i_m_tdata[0], want.ok));
                    if (i_m_tdata[32:1] !== want.element)
                        report_mismatch($sformatf("element got 0x%h want 0x%h",
                                                  i_m_tdata[32:1], want.element));
                    if (i_m_tdata[40:33] !== want.found)
                        report_mismatch($sformatf("found_position got %0d want %0d",
                                                  i_m_tdata[40:33], want.found));
                    if (i_m_tdata[48:41] !== want.count)
                        report_mismatch($sformatf("count got %0d want %0d",
                                                  i_m_tdata[48:41], want.count));
                    if (i_m_tdata[55:49] !== '0)
                        report_mismatch($sformatf("padding got 0x%h want 0",
                                                  i_m_tdata[55:49]));
                end
                reply_seq++;
            end
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(apply_request(t_kind'(i_s_tuser), i_s_tdata[7:0],
                                                    i_s_tdata[39:8]));
        end
        o_pending  <= replies_due.size();
        o_list_len <= 8'(shadow_len);
    end

endmodule

FILE: tb/testbench.sv
// Top of the positional list store testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import pls_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1320;
    localparam int SEGMENT      = 120;   // items between changes of direction and idling
    localparam int TAIL_ITEMS   = 150;   // final stretch with no idling at all
    localparam int LONG_HOLD    = 300;   // cycles the result side holds off once
    // With sender gaps, receiver stalls and the single long hold-off, this limit
    // leaves a wide margin over the slowest transaction.
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE       = 60;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [39:0] i_s_tdata  = '0;   // position [7:0], value [39:8]
    logic [1:0]  i_s_tuser  = '0;   // req_type [1:0]
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;         // ok [0], element [32:1], found_position [40:33],
                                    // count [48:41], zero [55:49]

    int          mismatches;
    int          pending;
    logic [7:0]  list_len;
    int          quiet_cycles = 0;

    // Knobs shared between the request and result processes.
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          tail_phase = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_served = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    positional_list_store #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    pls_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_list_len   (list_len)
    );

    // Offers one request and returns at the edge where the transaction is taken.
    // The valid stays high on return so back-to-back requests need no gap.
    task automatic send_request(input t_kind kind, input logic [7:0] pos,
                                input logic [31:0] val);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {val, pos};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops offering requests until the block has handed back every result owed.
    task automatic wait_until_drained();
        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side: ready in random bursts with short stalls, one long hold-off
    // on request from the stimulus, and always ready in the final stretch and while idling is off.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (tail_phase || !rx_idle_en) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    // Request side: reset, a directed opening, then biased random traffic.
    initial begin
        logic [31:0] value_pool [8];
        logic [31:0] val;
        logic [7:0]  pos;
        t_kind       kind;
        bit          grow;
        int          len;
        int          r;

        for (int i = 0; i < 8; i++) value_pool[i] = $urandom();
        value_pool[0] = 32'd7;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Requests against the empty list must all fail except locate.
        send_request(K_GET,    8'd1, 32'd0);
        send_request(K_DELETE, 8'd1, 32'd0);
        send_request(K_LOCATE, 8'd0, 32'd0);
        send_request(K_INSERT, 8'd0, 32'h1234_5678);
        send_request(K_INSERT, 8'd2, 32'h1234_5678);

        // Fill to capacity with head, tail and middle inserts, the value
        // extremes and repeated values so locate has duplicates to choose from.
        for (int i = 0; i < CAPACITY; i++) begin
            case (i % 3)
                0:       pos = 8'd1;
                1:       pos = 8'(i + 1);
                default: pos = 8'(i / 2 + 1);
            endcase
            case (i)
                0:       val = 32'h8000_0000;
                1:       val = 32'h7fff_ffff;
                2:       val = 32'h0000_0000;
                3:       val = 32'hffff_ffff;
                default: val = (i % 4 == 0) ? 32'd7 : {16'h5a5a, 16'(i)};
            endcase
            send_request(K_INSERT, pos, val);
        end

        // Full list, duplicates, the last slot and just past it.
        send_request(K_INSERT, 8'd1,   32'hdead_beef);
        send_request(K_LOCATE, 8'd0,   32'd7);
        send_request(K_GET,    8'd16,  32'd0);
        send_request(K_GET,    8'd17,  32'd0);
        send_request(K_GET,    8'd255, 32'd0);
        send_request(K_DELETE, 8'd16,  32'd0);
        send_request(K_DELETE, 8'd1,   32'd0);

        grow = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Swing the list between empty and full, and vary the idling.
            if (n % SEGMENT == 0) begin
                grow       = !grow;
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (n == RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
            if (n == 300) hold_req = 1'b1;
            if (n == 700) wait_until_drained();

            len = int'(list_len);
            r   = $urandom_range(0, 99);
            if (grow)
                kind = (r < 45) ? K_INSERT : (r < 60) ? K_DELETE : (r < 80) ? K_GET : K_LOCATE;
            else
                kind = (r < 15) ? K_INSERT : (r < 60) ? K_DELETE : (r < 80) ? K_GET : K_LOCATE;

            // Mostly legal positions, with a share of zero, just-past-the-end
            // and arbitrary bytes so bad positions and every bit are covered.
            case ($urandom_range(0, 9))
                0:       pos = 8'd0;
                1:       pos = 8'(len + 1);
                2:       pos = 8'(len + 2);
                3:       pos = 8'($urandom_range(0, 255));
                default: begin
                    if (kind == K_INSERT)
                        pos = 8'($urandom_range(1, len + 1));
                    else if (kind == K_LOCATE)
                        pos = 8'($urandom_range(0, 255));
                    else
                        pos = 8'($urandom_range(1, (len == 0) ? 1 : len));
                end
            endcase

            // Inserts and locates draw from a small pool so locates hit often.
            r = $urandom_range(0, 9);
            if ((kind == K_INSERT || kind == K_LOCATE) && r < 5)
                val = value_pool[$urandom_range(0, 7)];
            else if (r == 5)
                case ($urandom_range(0, 3))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    2:       val = 32'h0000_0000;
                    default: val = 32'hffff_ffff;
                endcase
            else
                val = $urandom();

            send_request(kind, pos, val);
            if (tx_idle_en && !tail_phase && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 5));
        end

        wait_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: ends the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
